// ----- src/delta_list_sleep_timer_assert.svh -----
// ----------------------------------------------------------------------------
// delta list sleep timer assertion macros
// clocked checks, masked while reset is asserted
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_SLEEP_TIMER_ASSERT_SVH
`define DELTA_LIST_SLEEP_TIMER_ASSERT_SVH

// check a property at every rising clock edge outside reset
`define DLST_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dlst check failed");

// implication form: antecedent and consequent in the same cycle
`define DLST_ASSERT_IMP(label, ante, cons) \
    `DLST_ASSERT(label, (ante) |-> (cons))

`endif

// ----- src/dlst_pkg.sv -----
// ----------------------------------------------------------------------------
// dlst_pkg
// shared types and codes for the delta list sleep timer
// ----------------------------------------------------------------------------
package dlst_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int DEF_THREADS = 16;
    localparam int DELTA_W     = 32;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_SLEEP = 1'b1;

    localparam logic [1:0] KIND_WOKEN  = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_WAKE,
        ST_SCMP,
        ST_INS,
        ST_LINK,
        ST_RES
    } state_t;

endpackage

// ----- src/delta_list_sleep_timer.sv -----
// ----------------------------------------------------------------------------
// delta_list_sleep_timer
// delta list of sleeping threads, woken by timer ticks
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one request: func 0 is a
//   timer tick, func 1 a sleep request of delay ticks for thread_id
//   output channel (out_valid / out_stall) carries results: kind, thread
//   and last, which marks the final result of a request
//   a sleep request walks the list from the head, one entry ram read per
//   cycle; an insert then writes the new entry and, if it has a
//   predecessor, the link of that entry
//   a tick that expires the head then scans the waiter mask, one thread
//   per cycle unless the receiver stalls
//   one request is in work at a time; in_stall is high while it runs
//   the result register lets a new request in while a result still waits
//   a stalled receiver holds the scan or the final step until it frees
//   reset empties the list at once: no clearing pass, the entry ram is
//   only read at slots that are on the list; free slots come from a
//   never-used count and a stack of released slots held in a second ram
// ----------------------------------------------------------------------------
`include "delta_list_sleep_timer_assert.svh"

module delta_list_sleep_timer
    import dlst_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int THREADS = DEF_THREADS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [DELTA_W-1:0] delay,
    input  logic [3:0]         thread_id,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [3:0]         woken_thread,
    output logic               last
);

    localparam int IW        = $clog2(ENTRIES);
    localparam int TW        = $clog2(THREADS);
    localparam int WAIT_LSB  = IW;
    localparam int DELTA_LSB = IW + THREADS;
    localparam int EW        = IW + THREADS + DELTA_W;
    localparam logic [IW:0] FULL = (IW + 1)'(ENTRIES);

    // control state
    state_t             state_reg, state_next;
    logic [IW-1:0]      head_reg, head_next;
    logic [IW:0]        used_reg, used_next;
    logic [IW:0]        sp_reg, sp_next;
    logic [IW:0]        fresh_reg, fresh_next;
    logic               out_valid_reg, out_valid_next;

    // request payload and walk state
    logic [DELTA_W-1:0] d_reg, d_next;
    logic [IW:0]        rem_reg, rem_next;
    logic [IW-1:0]      cur_reg, cur_next;
    logic [IW-1:0]      prev_reg, prev_next;
    logic               have_prev_reg, have_prev_next;
    logic [EW-IW-1:0]   prev_data_reg, prev_data_next;
    logic [IW-1:0]      link_tgt_reg, link_tgt_next;
    logic [IW-1:0]      new_slot_reg, new_slot_next;
    logic [3:0]         tid_reg, tid_next;
    logic [TW-1:0]      tmod_reg, tmod_next;
    logic [1:0]         res_kind_reg, res_kind_next;
    logic [THREADS-1:0] mask_reg, mask_next;
    logic [TW-1:0]      t_reg, t_next;
    logic [1:0]         out_kind_reg, out_kind_next;
    logic [3:0]         out_thread_reg, out_thread_next;
    logic               out_last_reg, out_last_next;

    // entry ram
    logic               ent_wr_en;
    logic [IW-1:0]      ent_wr_addr, ent_rd_addr;
    logic [EW-1:0]      ent_wr_data, ent_rd_data;
    logic [DELTA_W-1:0] e_delta;
    logic [THREADS-1:0] e_wait;
    logic [IW-1:0]      e_link;

    // free slot stack ram
    logic               stk_wr_en;
    logic [IW-1:0]      stk_rd_addr, stk_rd_data;
    logic [IW-1:0]      alloc_slot;

    logic               out_free;
    logic [THREADS-1:0] tbit, tclr;
    logic [6:0]         tm;
    logic [3:0]         t_ext;

    assign e_delta = ent_rd_data[DELTA_LSB +: DELTA_W];
    assign e_wait  = ent_rd_data[WAIT_LSB +: THREADS];
    assign e_link  = ent_rd_data[IW-1:0];

    assign stk_rd_addr = sp_reg[IW-1:0] - 1'b1;
    assign alloc_slot  = (sp_reg != '0) ? stk_rd_data : fresh_reg[IW-1:0];

    assign out_free = !out_valid_reg || !out_stall;
    assign tbit     = {{(THREADS-1){1'b0}}, 1'b1} << tmod_reg;
    assign tclr     = {{(THREADS-1){1'b0}}, 1'b1} << t_reg;
    assign t_ext    = 4'(t_reg);

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign woken_thread = out_thread_reg;
    assign last         = out_last_reg;

    // thread id folded into the thread range
    always_comb
    begin
        tm = 7'(thread_id);
        for (int i = 0; i < 8; i++)
        begin
            if (tm >= 7'(THREADS))
            begin
                tm = tm - 7'(THREADS);
            end
        end
    end

    dlst_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    dlst_ram #(
        .WIDTH (IW),
        .DEPTH (ENTRIES)
    ) u_free_ram (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (sp_reg[IW-1:0]),
        .wr_data (head_reg),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_TICK)
                    begin
                        state_next = (used_reg == '0) ? ST_IDLE : ST_TICK;
                    end
                    else
                    begin
                        state_next = (used_reg == '0) ? ST_INS : ST_SCMP;
                    end
                end
            end
            ST_TICK:
            begin
                state_next = (e_delta != '0) ? ST_IDLE : ST_WAKE;
            end
            ST_WAKE:
            begin
                if (mask_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCMP:
            begin
                priority if (d_reg < e_delta)
                begin
                    state_next = (used_reg == FULL) ? ST_RES : ST_INS;
                end
                else if (d_reg == e_delta)
                begin
                    state_next = ST_RES;
                end
                else if (rem_reg == (IW + 1)'(1))
                begin
                    state_next = (used_reg == FULL) ? ST_RES : ST_INS;
                end
                else
                begin
                    state_next = ST_SCMP;
                end
            end
            ST_INS:
            begin
                state_next = have_prev_reg ? ST_LINK : ST_RES;
            end
            ST_LINK:
            begin
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        head_next       = head_reg;
        used_next       = used_reg;
        sp_next         = sp_reg;
        fresh_next      = fresh_reg;
        d_next          = d_reg;
        rem_next        = rem_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        prev_data_next  = prev_data_reg;
        link_tgt_next   = link_tgt_reg;
        new_slot_next   = new_slot_reg;
        tid_next        = tid_reg;
        tmod_next       = tmod_reg;
        res_kind_next   = res_kind_reg;
        mask_next       = mask_reg;
        t_next          = t_reg;
        out_kind_next   = out_kind_reg;
        out_thread_next = out_thread_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ent_wr_en       = 1'b0;
        ent_wr_addr     = cur_reg;
        ent_wr_data     = ent_rd_data;
        ent_rd_addr     = head_reg;
        stk_wr_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                d_next         = delay;
                cur_next       = head_reg;
                rem_next       = used_reg;
                have_prev_next = 1'b0;
                tid_next       = thread_id;
                tmod_next      = tm[TW-1:0];
                link_tgt_next  = '0;
            end
            ST_TICK:
            begin
                if (e_delta != '0)
                begin
                    ent_wr_en   = 1'b1;
                    ent_wr_addr = head_reg;
                    ent_wr_data = {e_delta - 1'b1, e_wait, e_link};
                end
                else
                begin
                    // release the head slot onto the free stack
                    stk_wr_en = 1'b1;
                    sp_next   = sp_reg + 1'b1;
                    head_next = e_link;
                    used_next = used_reg - 1'b1;
                    mask_next = e_wait;
                    t_next    = '0;
                end
            end
            ST_WAKE:
            begin
                if (mask_reg != '0)
                begin
                    if (mask_reg[t_reg])
                    begin
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = KIND_WOKEN;
                            out_thread_next = t_ext;
                            out_last_next   = ((mask_reg & ~tclr) == '0);
                            mask_next       = mask_reg & ~tclr;
                            t_next          = t_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        t_next = t_reg + 1'b1;
                    end
                end
            end
            ST_SCMP:
            begin
                priority if (d_reg < e_delta)
                begin
                    if (used_reg == FULL)
                    begin
                        res_kind_next = KIND_REJECT;
                    end
                    else
                    begin
                        // split: the new entry goes in before this one
                        ent_wr_en     = 1'b1;
                        ent_wr_data   = {e_delta - d_reg, e_wait, e_link};
                        link_tgt_next = cur_reg;
                    end
                end
                else if (d_reg == e_delta)
                begin
                    ent_wr_en     = 1'b1;
                    ent_wr_data   = {e_delta, e_wait | tbit, e_link};
                    res_kind_next = KIND_ACCEPT;
                end
                else
                begin
                    d_next         = d_reg - e_delta;
                    prev_next      = cur_reg;
                    prev_data_next = ent_rd_data[EW-1:IW];
                    have_prev_next = 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    cur_next       = e_link;
                    ent_rd_addr    = e_link;
                    link_tgt_next  = '0;
                    if (rem_reg == (IW + 1)'(1) && used_reg == FULL)
                    begin
                        res_kind_next = KIND_REJECT;
                    end
                end
            end
            ST_INS:
            begin
                ent_wr_en     = 1'b1;
                ent_wr_addr   = alloc_slot;
                ent_wr_data   = {d_reg, tbit, link_tgt_reg};
                new_slot_next = alloc_slot;
                used_next     = used_reg + 1'b1;
                res_kind_next = KIND_ACCEPT;
                if (sp_reg != '0)
                begin
                    sp_next = sp_reg - 1'b1;
                end
                else
                begin
                    fresh_next = fresh_reg + 1'b1;
                end
                if (!have_prev_reg)
                begin
                    head_next = alloc_slot;
                end
            end
            ST_LINK:
            begin
                ent_wr_en   = 1'b1;
                ent_wr_addr = prev_reg;
                ent_wr_data = {prev_data_reg, new_slot_reg};
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = res_kind_reg;
                    out_thread_next = tid_reg;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            used_reg      <= '0;
            sp_reg        <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            used_reg      <= used_next;
            sp_reg        <= sp_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg          <= d_next;
        rem_reg        <= rem_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        have_prev_reg  <= have_prev_next;
        prev_data_reg  <= prev_data_next;
        link_tgt_reg   <= link_tgt_next;
        new_slot_reg   <= new_slot_next;
        tid_reg        <= tid_next;
        tmod_reg       <= tmod_next;
        res_kind_reg   <= res_kind_next;
        mask_reg       <= mask_next;
        t_reg          <= t_next;
        out_kind_reg   <= out_kind_next;
        out_thread_reg <= out_thread_next;
        out_last_reg   <= out_last_next;
    end

    // list occupancy never exceeds the store
    `DLST_ASSERT(a_used_bound, used_reg <= FULL)
    // slots on the list are exactly those handed out and not yet released
    `DLST_ASSERT(a_slot_books, used_reg == fresh_reg - sp_reg)
    // a wake result only comes from the waiter scan
    `DLST_ASSERT_IMP(a_wake_src, $rose(out_valid_reg) && out_kind_reg == KIND_WOKEN,
        $past(state_reg) == ST_WAKE)

endmodule

// ----- src/dlst_ram.sv -----
// ----------------------------------------------------------------------------
// dlst_ram
// generic simple dual port ram, one write port, registered read
// ----------------------------------------------------------------------------
module dlst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- tb/sv/delta_list_sleep_timer_tb.sv -----
// ----------------------------------------------------------------------------
// delta_list_sleep_timer_tb
// drives ticks and sleep requests into the delta list sleep timer and checks
// every wake, accept and reject result against a predictor of the list
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module delta_list_sleep_timer_tb;
    import dlst_pkg::*;

    localparam int SLOTS  = DEF_ENTRIES;
    localparam int THR    = DEF_THREADS;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] thr;
        logic       last;
    } timer_result_t;

    // ------------------------------------------------------------------
    // list predictor and store of expected results
    // ------------------------------------------------------------------
    class timer_scoreboard;
        logic [31:0]     slot_delta[SLOTS];
        logic [THR-1:0]  slot_waiters[SLOTS];
        int              slot_link[SLOTS];
        bit              slot_busy[SLOTS];
        int              head;
        int              used;
        timer_result_t   pending[$];
        int              errors;
        int              wakes, accepts, rejects;

        function new();
            head = 0;
            used = 0;
            errors = 0;
            wakes = 0; accepts = 0; rejects = 0;
            foreach (slot_busy[i]) slot_busy[i] = 0;
        endfunction

        function int take_slot();
            for (int i = 0; i < SLOTS; i++)
                if (!slot_busy[i])
                begin
                    slot_busy[i] = 1;
                    used++;
                    return i;
                end
            return 0;
        endfunction

        function void push(logic [1:0] k, logic [3:0] t, logic l);
            timer_result_t r;
            r.kind = k; r.thr = t; r.last = l;
            pending.push_back(r);
        endfunction

        // work out the results of one accepted request
        function void note_request(logic f, logic [31:0] dly, logic [3:0] tid);
            logic [31:0]    rem;
            logic [THR-1:0] mask;
            int cur, prev, s, n, cnt;
            bit have_prev;
            if (f == FUNC_TICK)
            begin
                if (used == 0) return;
                if (slot_delta[head] != 0)
                begin
                    slot_delta[head]--;
                    return;
                end
                mask = slot_waiters[head];
                slot_busy[head] = 0;
                used--;
                head = slot_link[head];
                cnt = $countones(mask);
                n = 0;
                for (int t = 0; t < THR; t++)
                    if (mask[t])
                    begin
                        n++;
                        push(KIND_WOKEN, t[3:0], n == cnt);
                    end
                return;
            end
            rem = dly;
            cur = head;
            prev = 0;
            have_prev = 0;
            n = used;
            for (int i = 0; i < n; i++)
            begin
                if (rem < slot_delta[cur])
                begin
                    if (used >= SLOTS)
                    begin
                        push(KIND_REJECT, tid, 1'b1);
                        return;
                    end
                    s = take_slot();
                    slot_delta[cur] -= rem;
                    slot_delta[s] = rem;
                    slot_waiters[s] = '0;
                    slot_waiters[s][tid % THR] = 1'b1;
                    slot_link[s] = cur;
                    if (have_prev) slot_link[prev] = s;
                    else head = s;
                    push(KIND_ACCEPT, tid, 1'b1);
                    return;
                end
                if (rem == slot_delta[cur])
                begin
                    slot_waiters[cur][tid % THR] = 1'b1;
                    push(KIND_ACCEPT, tid, 1'b1);
                    return;
                end
                rem -= slot_delta[cur];
                prev = cur;
                have_prev = 1;
                cur = slot_link[cur];
            end
            if (used >= SLOTS)
            begin
                push(KIND_REJECT, tid, 1'b1);
                return;
            end
            s = take_slot();
            slot_delta[s] = rem;
            slot_waiters[s] = '0;
            slot_waiters[s][tid % THR] = 1'b1;
            slot_link[s] = 0;
            if (have_prev) slot_link[prev] = s;
            else head = s;
            push(KIND_ACCEPT, tid, 1'b1);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic [1:0] k, logic [3:0] t, logic l);
            timer_result_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d thread %0d", k, t));
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind)
                report($sformatf("kind %0d, expected %0d", k, e.kind));
            if (t !== e.thr)
                report($sformatf("thread %0d, expected %0d", t, e.thr));
            if (l !== e.last)
                report($sformatf("last %0d, expected %0d", l, e.last));
            if (e.kind == KIND_WOKEN) wakes++;
            else if (e.kind == KIND_ACCEPT) accepts++;
            else rejects++;
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        func = FUNC_TICK;
    logic [31:0] delay = '0;
    logic [3:0]  thread_id = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [3:0]  woken_thread;
    logic        last;

    timer_scoreboard sb = new();
    bit quiet_sender;   // long stretch with no gaps on either side
    bit quiet_receiver;
    int requests_sent;

    always #2 clk = ~clk;

    delta_list_sleep_timer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .delay(delay), .thread_id(thread_id),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .woken_thread(woken_thread), .last(last)
    );

    // receiver: random stall, results checked at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(kind, woken_thread, last);
        out_stall <= quiet_receiver ? 1'b0 : ($urandom_range(0, 99) < 33);
    end

    // one request: optional random gap, then hold until accepted
    task automatic send_request(input logic f, input logic [31:0] dly, input logic [3:0] tid);
        if (!quiet_sender && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (!quiet_sender && $urandom_range(0, 99) < 33)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        delay     <= dly;
        thread_id <= tid;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge
        sb.note_request(f, dly, tid);
        requests_sent++;
    endtask

    task automatic send_tick();
        send_request(FUNC_TICK, $urandom, 4'($urandom_range(0, 15)));
    endtask

    task automatic send_sleep(input logic [31:0] dly, input logic [3:0] tid);
        send_request(FUNC_SLEEP, dly, tid);
    endtask

    // hold off until the list has delivered every pending result
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // short delays so that ticks actually expire entries
    function automatic logic [31:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 6);
        if (r < 90) return $urandom_range(0, 40);
        if (r < 95) return 32'hFFFF_FFFF - $urandom_range(0, 3);
        return $urandom;
    endfunction

    initial
    begin
        requests_sent = 0;
        quiet_sender = 0;
        quiet_receiver = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list tick, tail insert, join, split, extremes
        send_tick();
        send_sleep(32'd0, 4'd0);
        send_sleep(32'd0, 4'd15);         // joins head with zero delta
        send_sleep(32'd3, 4'd5);          // tail
        send_sleep(32'd1, 4'd6);          // split before tail entry
        send_sleep(32'd3, 4'd7);          // joins after walking
        send_sleep(32'hFFFF_FFFF, 4'd10); // largest delay at tail
        send_tick();                      // wake 0 and 15 in order
        send_tick();                      // decrement
        send_tick();
        send_tick();
        drain();
        // fill the store, then reject and join while full
        for (int i = 0; i < SLOTS + 2; i++)
            send_sleep(32'd100 + i, i[3:0]);
        send_sleep(32'd100, 4'd9);        // join at full store
        drain();
        // expire all but the far tail entry with a long run of ticks, no idling
        quiet_sender = 1;
        quiet_receiver = 1;
        for (int i = 0; i < 140; i++)
            send_tick();
        quiet_sender = 0;
        quiet_receiver = 0;
        drain();

        // random part
        for (int i = 0; i < 290; i++)
        begin
            if (i == 100) quiet_sender = 1;
            if (i == 100) quiet_receiver = 1;
            if (i == 180) quiet_sender = 0;
            if (i == 180) quiet_receiver = 0;
            if (i == 200) drain();
            if ($urandom_range(0, 99) < 50)
                send_tick();
            else
                send_sleep(pick_delay(), 4'($urandom_range(0, 15)));
        end

        drain();
        $display("sent %0d requests: %0d wakes, %0d accepts, %0d rejects checked",
                 requests_sent, sb.wakes, sb.accepts, sb.rejects);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule
